### src/bres_pkg.sv
// ----------------------------------------------------------------------------
// bres_pkg
// Shared widths, register codes and bundle types of the line rasterizer.
// ----------------------------------------------------------------------------
package bres_pkg;

  localparam int CoordW      = 6;
  localparam int CoordBitsDef = 6;
  localparam int ErrW        = CoordW + 2;
  localparam int PitchW      = 7;
  localparam int ColourW     = 24;
  localparam int AddrW       = 12;
  localparam int ApbAddrW    = 3;
  localparam int ApbDataW    = 32;

  localparam logic [PitchW-1:0]  PitchRst  = 7'd64;
  localparam logic [ColourW-1:0] ColourRst = 24'hFF_FFFF;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_PITCH  = 1'b0,
    REG_COLOUR = 1'b1
  } reg_idx_e;

  // endpoints of the segment being set up
  typedef struct packed {
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic [CoordW-1:0] x2;
    logic [CoordW-1:0] y2;
  } seg_t;

  // walk parameters, major axis a, minor axis b
  typedef struct packed {
    logic                   steep;
    logic                   step_dn;
    logic [CoordW-1:0]      a_start;
    logic [CoordW-1:0]      a_end;
    logic [CoordW-1:0]      b_start;
    logic signed [ErrW-1:0] err;
    logic signed [ErrW-1:0] db2;
    logic signed [ErrW-1:0] dd2;
  } line_t;

endpackage

### src/bres_if.sv
// ----------------------------------------------------------------------------
// bres_seg_if / bres_pix_if
// Valid/ready channels for segment words in and pixel words out.
// ----------------------------------------------------------------------------
interface bres_seg_if;
  logic                          valid;
  logic                          ready;
  logic [bres_pkg::CoordW-1:0]   start_x;
  logic [bres_pkg::CoordW-1:0]   start_y;
  logic [bres_pkg::CoordW-1:0]   end_x;
  logic [bres_pkg::CoordW-1:0]   end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface bres_pix_if;
  logic                          valid;
  logic                          ready;
  logic [bres_pkg::CoordW-1:0]   pixel_x;
  logic [bres_pkg::CoordW-1:0]   pixel_y;
  logic [bres_pkg::AddrW-1:0]    pixel_address;
  logic [bres_pkg::ColourW-1:0]  pixel_colour;
  logic                          last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                  last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                  last_pixel, output ready);
endinterface

### src/bres_regs.sv
// ----------------------------------------------------------------------------
// bres_regs
// APB register file holding row pitch and draw colour.
// ----------------------------------------------------------------------------
module bres_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bres_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bres_pkg::ApbDataW-1:0]  pwdata,
  output logic [bres_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output logic [bres_pkg::PitchW-1:0]    pitch_o,
  output logic [bres_pkg::ColourW-1:0]   colour_o
);

  logic [bres_pkg::PitchW-1:0]  pitch_q;
  logic [bres_pkg::ColourW-1:0] colour_q;
  bres_pkg::reg_idx_e           idx;
  logic                         wr_en;

  assign idx   = bres_pkg::reg_idx_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q  <= bres_pkg::PitchRst;
      colour_q <= bres_pkg::ColourRst;
    end else if (wr_en) begin
      case (idx)
        bres_pkg::REG_PITCH:  pitch_q  <= pwdata[bres_pkg::PitchW-1:0];
        bres_pkg::REG_COLOUR: colour_q <= pwdata[bres_pkg::ColourW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bres_pkg::REG_PITCH:
        prdata = bres_pkg::ApbDataW'(pitch_q);
      bres_pkg::REG_COLOUR:
        prdata = bres_pkg::ApbDataW'(colour_q);
      default:
        prdata = '0;
    endcase
  end

  assign pitch_o  = pitch_q;
  assign colour_o = colour_q;

endmodule

### src/bres_setup.sv
// ----------------------------------------------------------------------------
// bres_setup
// Octant reduction: picks the major axis, orders the endpoints and derives
// the initial error term and step increments.
// ----------------------------------------------------------------------------
module bres_setup (
  input  bres_pkg::seg_t  seg_i,
  output bres_pkg::line_t line_o
);

  logic [bres_pkg::CoordW-1:0] adx, ady, da, db;
  logic [bres_pkg::CoordW-1:0] p1, q1, p2, q2;
  logic                        steep, swap;

  always_comb begin
    adx   = (seg_i.x2 > seg_i.x1) ? seg_i.x2 - seg_i.x1 : seg_i.x1 - seg_i.x2;
    ady   = (seg_i.y2 > seg_i.y1) ? seg_i.y2 - seg_i.y1 : seg_i.y1 - seg_i.y2;
    steep = ady > adx;
    p1    = steep ? seg_i.y1 : seg_i.x1;
    q1    = steep ? seg_i.x1 : seg_i.y1;
    p2    = steep ? seg_i.y2 : seg_i.x2;
    q2    = steep ? seg_i.x2 : seg_i.y2;
    // equal major coordinates keep their order
    swap  = p1 > p2;

    line_o.steep   = steep;
    line_o.a_start = swap ? p2 : p1;
    line_o.a_end   = swap ? p1 : p2;
    line_o.b_start = swap ? q2 : q1;
    da = line_o.a_end - line_o.a_start;
    if (swap) begin
      db             = (q1 > q2) ? q1 - q2 : q2 - q1;
      line_o.step_dn = !(q2 < q1);
    end else begin
      db             = (q2 > q1) ? q2 - q1 : q1 - q2;
      line_o.step_dn = !(q1 < q2);
    end
    line_o.err = $signed({2'b00, da});
    line_o.db2 = $signed({1'b0, db, 1'b0});
    // db never exceeds da here
    line_o.dd2 = $signed({1'b0, da - db, 1'b0});
  end

endmodule

### src/bres_stepper.sv
// ----------------------------------------------------------------------------
// bres_stepper
// Sequencer around one error-term update unit; walks the major axis one
// pixel per cycle, unless the pixel output stalls, into an output register.
// ----------------------------------------------------------------------------
module bres_stepper #(
  parameter int COORD_BITS = bres_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bres_seg_if.sink                      seg_i,
  bres_pix_if.source                    pix_o,
  input  logic [bres_pkg::PitchW-1:0]   pitch_i,
  input  logic [bres_pkg::ColourW-1:0]  colour_i,
  output bres_pkg::seg_t                seg_o,
  input  bres_pkg::line_t               line_i
);

  localparam int CW = bres_pkg::CoordW;
  localparam int EW = bres_pkg::ErrW;
  localparam logic [CW-1:0] CoordMask = CW'((1 << COORD_BITS) - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  bres_pkg::seg_t         seg_q;
  logic                   steep_q, step_dn_q;
  logic [CW-1:0]          a_q, a_end_q, b_q;
  logic signed [EW-1:0]   err_q, db2_q, dd2_q;

  logic                   out_valid_q;
  logic [CW-1:0]          px_q, py_q;
  logic [bres_pkg::AddrW-1:0] addr_q;
  logic                   last_q;

  logic                   accept, load, is_last;
  logic signed [EW-1:0]   e_sub, e_add, err_d;
  logic [CW-1:0]          b_d, px, py;
  logic [CW+bres_pkg::PitchW-1:0] prod;
  logic [bres_pkg::AddrW-1:0]     addr;

  assign seg_i.ready = (state_q == ST_IDLE);
  assign accept      = seg_i.valid && seg_i.ready;
  assign load        = (state_q == ST_RUN) && (!out_valid_q || pix_o.ready);
  assign is_last     = (a_q == a_end_q);
  assign seg_o       = seg_q;

  // shared error unit
  always_comb begin
    e_sub = err_q - db2_q;
    e_add = err_q + dd2_q;
    err_d = e_sub[EW-1] ? e_add : e_sub;
    if (e_sub[EW-1]) begin
      b_d = step_dn_q ? b_q - CW'(1) : b_q + CW'(1);
    end else begin
      b_d = b_q;
    end
    px   = steep_q ? b_q : a_q;
    py   = steep_q ? a_q : b_q;
    prod = py * pitch_i;
    addr = bres_pkg::AddrW'(prod) + bres_pkg::AddrW'(px);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_RUN;
      ST_RUN:   if (load && is_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seg_q.x1 <= seg_i.start_x & CoordMask;
      seg_q.y1 <= seg_i.start_y & CoordMask;
      seg_q.x2 <= seg_i.end_x & CoordMask;
      seg_q.y2 <= seg_i.end_y & CoordMask;
    end
    if (state_q == ST_SETUP) begin
      steep_q   <= line_i.steep;
      step_dn_q <= line_i.step_dn;
      a_q       <= line_i.a_start;
      a_end_q   <= line_i.a_end;
      b_q       <= line_i.b_start;
      err_q     <= line_i.err;
      db2_q     <= line_i.db2;
      dd2_q     <= line_i.dd2;
    end else if (load) begin
      a_q   <= a_q + CW'(1);
      b_q   <= b_d;
      err_q <= err_d;
    end
    if (load) begin
      px_q   <= px;
      py_q   <= py;
      addr_q <= addr;
      last_q <= is_last;
    end
  end

  assign pix_o.valid         = out_valid_q;
  assign pix_o.pixel_x       = px_q;
  assign pix_o.pixel_y       = py_q;
  assign pix_o.pixel_address = addr_q;
  assign pix_o.pixel_colour  = colour_i;
  assign pix_o.last_pixel    = last_q;

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && is_last) |=> (state_q == ST_IDLE))
    else $error("walk did not end on last pixel");

  a_accept_to_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SETUP))
    else $error("accepted segment not set up");

  a_major_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (a_q <= a_end_q))
    else $error("major coordinate ran past endpoint");

  a_err_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !err_q[EW-1])
    else $error("error term negative between steps");

endmodule

### src/bresenham_line_rasterizer.sv
// Flow: the accepted segment word is registered and set up in ST_SETUP; pixel words follow from ST_RUN.
// Occupancy: a segment of n pixels (n = major extent + 1, up to 64) holds the
// block while its pixels are walked; one error-term update unit steps once
// per pixel, and the next segment is taken only after the last pixel is loaded.
// Reset: control clears at once, row pitch returns to 64, colour to 0xFFFFFF.
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Top level: APB registers, octant setup and the pixel stepping sequencer.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = bres_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bres_seg_if.sink                       seg_i,
  bres_pix_if.source                     pix_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bres_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bres_pkg::ApbDataW-1:0]  pwdata,
  output logic [bres_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  logic [bres_pkg::PitchW-1:0]  pitch;
  logic [bres_pkg::ColourW-1:0] colour;
  bres_pkg::seg_t               seg;
  bres_pkg::line_t              line;

  bres_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .pitch_o  (pitch),
    .colour_o (colour)
  );

  bres_setup u_setup (
    .seg_i  (seg),
    .line_o (line)
  );

  bres_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .seg_i    (seg_i),
    .pix_o    (pix_o),
    .pitch_i  (pitch),
    .colour_i (colour),
    .seg_o    (seg),
    .line_i   (line)
  );

endmodule

### tb/line_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_pixel_checker
// Watches the segment, pixel and register ports of the line rasterizer,
// walks every accepted segment with its own copy of the registers and
// compares each pixel word with the oldest pixel still due.
// ----------------------------------------------------------------------------
module line_pixel_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bres_seg_if                           seg,
  bres_pix_if                           pix,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [bres_pkg::ApbAddrW-1:0] paddr,
  input  logic [bres_pkg::ApbDataW-1:0] pwdata,
  input  logic [bres_pkg::ApbDataW-1:0] prdata,
  output int                            mismatch_count_o,
  output int                            pixels_due_o
);
  import bres_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic [AddrW-1:0]   addr;
    logic [ColourW-1:0] colour;
    logic               last;
  } pixel_t;

  pixel_t             pixels_due_q[$];
  logic [PitchW-1:0]  pitch_q    = PitchRst;
  logic [ColourW-1:0] colour_q   = ColourRst;
  int                 mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // walk one segment along its major axis and queue every pixel it covers
  function automatic void walk_segment(input logic [CoordW-1:0] x1, input logic [CoordW-1:0] y1,
                                       input logic [CoordW-1:0] x2, input logic [CoordW-1:0] y2);
    int     ix1, iy1, ix2, iy2, adx, ady;
    int     a1, b1, a2, b2, tmp;
    int     da, db, dir, err, a, b, addr;
    bit     steep;
    pixel_t px;
    ix1 = x1;
    iy1 = y1;
    ix2 = x2;
    iy2 = y2;
    adx = (ix2 > ix1) ? ix2 - ix1 : ix1 - ix2;
    ady = (iy2 > iy1) ? iy2 - iy1 : iy1 - iy2;
    steep = ady > adx;
    if (steep) begin
      a1 = iy1; b1 = ix1; a2 = iy2; b2 = ix2;
    end else begin
      a1 = ix1; b1 = iy1; a2 = ix2; b2 = iy2;
    end
    // endpoints with equal major coordinate keep their order
    if (a1 > a2) begin
      tmp = a1; a1 = a2; a2 = tmp;
      tmp = b1; b1 = b2; b2 = tmp;
    end
    da  = a2 - a1;
    db  = (b2 > b1) ? b2 - b1 : b1 - b2;
    dir = (b1 < b2) ? 1 : -1;
    err = da;
    b   = b1;
    for (a = a1; a <= a2; a++) begin
      px.x      = steep ? CoordW'(b) : CoordW'(a);
      px.y      = steep ? CoordW'(a) : CoordW'(b);
      addr      = int'(px.x) + int'(px.y) * int'(pitch_q);
      px.addr   = addr[AddrW-1:0];
      px.colour = colour_q;
      px.last   = (a == a2);
      pixels_due_q.push_back(px);
      err -= 2 * db;
      if (err < 0) begin
        b   += dir;
        err += 2 * da;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, want;
    logic [ApbDataW-1:0] reg_value;
    if (!rst_ni) begin
      pitch_q  = PitchRst;
      colour_q = ColourRst;
      pixels_due_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_e'(paddr[2]))
            REG_PITCH: begin
              pitch_q = pwdata[PitchW-1:0];
            end
            REG_COLOUR: begin
              colour_q = pwdata[ColourW-1:0];
            end
            default: ;
          endcase
        end else begin
          reg_value = (reg_idx_e'(paddr[2]) == REG_COLOUR) ? ApbDataW'(colour_q)
                                                          : ApbDataW'(pitch_q);
          if (prdata !== reg_value) report("prdata", prdata, reg_value);
        end
      end
      if (pix.valid && pix.ready) begin
        got = '{pix.pixel_x, pix.pixel_y, pix.pixel_address, pix.pixel_colour,
                pix.last_pixel};
        if (pixels_due_q.size() == 0) begin
          report("unexpected pixel word (x,y)", {got.x, got.y}, 0);
        end else begin
          want = pixels_due_q.pop_front();
          if (got.x !== want.x)           report("pixel_x", got.x, want.x);
          if (got.y !== want.y)           report("pixel_y", got.y, want.y);
          if (got.addr !== want.addr)     report("pixel_address", got.addr, want.addr);
          if (got.colour !== want.colour) report("pixel_colour", got.colour, want.colour);
          if (got.last !== want.last)     report("last_pixel", got.last, want.last);
        end
      end
      if (seg.valid && seg.ready) begin
        walk_segment(seg.start_x, seg.start_y, seg.end_x, seg.end_y);
      end
    end
    pixels_due_o = pixels_due_q.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives line segments and register writes into the line rasterizer with
// random idling on both channels and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;
  import bres_pkg::*;

  localparam int StallLimit = 2000;
  localparam int NumPhases  = 6;

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  int                  mismatches;
  int                  pixels_due;
  int                  seg_gap_odds   = 4;  // one in n words waits first, 0 = never
  int                  pix_stall_odds = 6;  // a stall starts with odds of one in n, 0 = never
  int                  quiet_cycles   = 0;

  bres_seg_if seg_if ();
  bres_pix_if pix_if ();

  bresenham_line_rasterizer DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .seg_i   (seg_if),
    .pix_o   (pix_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  line_pixel_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .seg              (seg_if),
    .pix              (pix_if),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .mismatch_count_o (mismatches),
    .pixels_due_o     (pixels_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pixel sink with random stall bursts
  initial begin
    pix_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && pix_stall_odds != 0 && $urandom_range(1, pix_stall_odds) == 1) begin
        pix_if.ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      pix_if.ready = rst_n;
    end
  end

  task automatic send_segment(input logic [CoordW-1:0] x1, input logic [CoordW-1:0] y1,
                              input logic [CoordW-1:0] x2, input logic [CoordW-1:0] y2);
    if (seg_gap_odds != 0 && $urandom_range(1, seg_gap_odds) == 1) begin
      seg_if.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    seg_if.valid   = 1'b1;
    seg_if.start_x = x1;
    seg_if.start_y = y1;
    seg_if.end_x   = x2;
    seg_if.end_y   = y2;
    do @(posedge clk); while (!seg_if.ready);
    @(negedge clk);
  endtask

  task automatic send_random_segment();
    logic [CoordW-1:0] x1, y1, x2, y2;
    int                kind, span;
    kind = $urandom_range(0, 9);
    span = $urandom_range(0, 63);
    x1   = CoordW'($urandom());
    y1   = CoordW'($urandom());
    x2   = CoordW'($urandom());
    y2   = CoordW'($urandom());
    case (kind)
      0, 1, 2: begin
        // short segment around the first endpoint
        x2 = CoordW'(int'(x1) + $urandom_range(0, 8) - 4);
        y2 = CoordW'(int'(y1) + $urandom_range(0, 8) - 4);
      end
      3: y2 = y1;
      4: x2 = x1;
      5: begin
        x2 = (x1 > 31) ? CoordW'(int'(x1) - span / 2) : CoordW'(int'(x1) + span / 2);
        y2 = (y1 > 31) ? CoordW'(int'(y1) - span / 2) : CoordW'(int'(y1) + span / 2);
      end
      6: begin
        x2 = x1;
        y2 = y1;
      end
      default: ;
    endcase
    send_segment(x1, y1, x2, y2);
  endtask

  task automatic apb_access(input logic write, input reg_idx_e idx, input logic [ApbDataW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // random upper bits go along to show they are dropped
  task automatic set_registers(input logic [PitchW-1:0] pitch, input logic [ColourW-1:0] colour);
    logic [ApbDataW-1:0] word;
    word = $urandom();
    word[PitchW-1:0] = pitch;
    apb_access(1'b1, REG_PITCH, word);
    apb_access(1'b0, REG_PITCH, $urandom());
    word = $urandom();
    word[ColourW-1:0] = colour;
    apb_access(1'b1, REG_COLOUR, word);
    apb_access(1'b0, REG_COLOUR, $urandom());
  endtask

  task automatic wait_idle();
    seg_if.valid = 1'b0;
    while (pixels_due != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if ((seg_if.valid && seg_if.ready) || (pix_if.valid && pix_if.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [PitchW-1:0]  pitch;
    logic [ColourW-1:0] colour;
    seg_if.valid   = 1'b0;
    seg_if.start_x = '0;
    seg_if.start_y = '0;
    seg_if.end_x   = '0;
    seg_if.end_y   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset values read back, then directed segments
    apb_access(1'b0, REG_PITCH, '0);
    apb_access(1'b0, REG_COLOUR, '0);
    send_segment(6'd0, 6'd0, 6'd0, 6'd0);        // single pixel
    send_segment(6'd63, 6'd63, 6'd63, 6'd63);
    send_segment(6'd0, 6'd0, 6'd63, 6'd0);       // full horizontal
    send_segment(6'd63, 6'd63, 6'd0, 6'd63);
    send_segment(6'd0, 6'd0, 6'd0, 6'd63);       // full vertical
    send_segment(6'd5, 6'd63, 6'd5, 6'd0);
    send_segment(6'd0, 6'd0, 6'd63, 6'd63);      // diagonals, not steep
    send_segment(6'd63, 6'd0, 6'd0, 6'd63);
    send_segment(6'd0, 6'd63, 6'd63, 6'd0);
    send_segment(6'd63, 6'd63, 6'd0, 6'd0);
    send_segment(6'd2, 6'd10, 6'd40, 6'd21);     // shallow rising
    send_segment(6'd40, 6'd21, 6'd2, 6'd30);     // shallow falling, swapped
    send_segment(6'd10, 6'd2, 6'd21, 6'd40);     // steep rising
    send_segment(6'd33, 6'd60, 6'd20, 6'd1);     // steep, swapped
    send_segment(6'd12, 6'd12, 6'd13, 6'd12);
    send_segment(6'd12, 6'd12, 6'd12, 6'd11);
    send_segment(6'd0, 6'd1, 6'd63, 6'd0);
    send_segment(6'd1, 6'd63, 6'd0, 6'd0);
    wait_idle();

    for (int phase = 0; phase < NumPhases; phase++) begin
      colour = ColourW'($urandom());
      case (phase)
        0: begin
          pitch = 7'd1; colour = '0; seg_gap_odds = 3; pix_stall_odds = 3;
        end
        1: begin
          pitch = 7'd64; seg_gap_odds = 0; pix_stall_odds = 4;
        end
        2: begin
          pitch = 7'd127; colour = '1; seg_gap_odds = 5; pix_stall_odds = 0;
        end
        3: begin
          pitch = 7'd0; seg_gap_odds = 2; pix_stall_odds = 2;
        end
        4: begin
          pitch = PitchW'($urandom_range(1, 64)); seg_gap_odds = 8; pix_stall_odds = 8;
        end
        default: begin
          // closing stretch runs at full rate
          pitch = PitchW'($urandom()); seg_gap_odds = 0; pix_stall_odds = 0;
        end
      endcase
      set_registers(pitch, colour);
      repeat (22) send_random_segment();
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0 && pixels_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
